>>> sv/adc_scan_deadband_reporter_core_defines.svh
// Assertion macros shared by the adc scan deadband reporter RTL.
// Every macro expects clk and arst_n in the scope where it is used.
`ifndef ADC_SCAN_DEADBAND_REPORTER_CORE_DEFINES_SVH
`define ADC_SCAN_DEADBAND_REPORTER_CORE_DEFINES_SVH

// A property that must hold at every rising edge outside reset.
`define ADSDR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be true at a rising edge outside reset.
`define ADSDR_ASSERT_NEVER(label, cond, msg) \
	`ADSDR_ASSERT(label, !(cond), msg)

`endif

>>> sv/adsdr_pkg.sv
// Package for the adc scan deadband reporter: sizes, frame codes and shared types.
// Used by every module of the block; depends on nothing.
package adsdr_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int SAMPLE_BITS  = 10;

	localparam int CH_SEL_W    = $clog2(NUM_CHANNELS);
	localparam int CH_W        = 3;
	localparam int SETTLE_W    = 16;
	localparam int CNT_W       = SETTLE_W + 1;
	localparam int DB_W        = 10;
	localparam int IN_W        = 10;
	localparam int BYTE_W      = 7;
	localparam int EXT_W       = 2 * BYTE_W;
	localparam int DIFF_CMP_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int LAST_CH_BASE = 3;
	localparam int LAST_CH_EXP  = 5;

	localparam logic [BYTE_W-1:0] FRAME_START = 7'h11;
	localparam logic [BYTE_W-1:0] FRAME_STOP  = 7'h13;

	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 16'd100;
	localparam logic [DB_W-1:0]     DB_WIDTH_RST     = 10'd1;
	localparam logic [CH_W-1:0]     CHANNEL_RST      = 3'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE_TICKS     = 2'd0,
		REG_DEADBAND_ENABLE  = 2'd1,
		REG_DEADBAND_WIDTH   = 2'd2,
		REG_EXPANDER_PRESENT = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [SETTLE_W-1:0] settle_ticks;
		logic                deadband_enable;
		logic [DB_W-1:0]     deadband_width;
		logic                expander_present;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]        channel;
		logic [SAMPLE_BITS-1:0] value;
	} frame_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> sv/adsdr_front.sv
// Front end: settle counter, channel scan, per-channel store and deadband filter.
// Emits one frame descriptor per changed channel value; depends on adsdr_pkg.
module adsdr_front import adsdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic [IN_W-1:0]   adc_sample,
	output logic              desc_valid,
	output frame_desc_t       desc
);

	logic [CNT_W-1:0]       settle_count_q;
	logic [CH_W-1:0]        channel_index_q;
	logic [SAMPLE_BITS-1:0] chan_value_q [NUM_CHANNELS];

	logic                   settled;
	logic [CH_W-1:0]        top_ch;
	logic [CH_W-1:0]        next_ch;
	logic [CH_W-1:0]        ch_sel;
	logic [SAMPLE_BITS-1:0] sample;
	logic [SAMPLE_BITS-1:0] stored;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0] accepted;
	logic                   outside_band;
	logic                   changed;

	always_comb begin
		settled = settle_count_q > {1'b0, cfg.settle_ticks};
		top_ch = cfg.expander_present ? CH_W'(LAST_CH_EXP) : CH_W'(LAST_CH_BASE);
		if (top_ch > CH_W'(NUM_CHANNELS - 1)) begin
			top_ch = CH_W'(NUM_CHANNELS - 1);
		end
		next_ch = (channel_index_q < top_ch) ? channel_index_q + 1'b1 : '0;
		ch_sel = ({1'b0, next_ch} >= (CH_W + 1)'(NUM_CHANNELS)) ? '0 : next_ch;
		sample = SAMPLE_BITS'(adc_sample);
		stored = chan_value_q[ch_sel[CH_SEL_W-1:0]];
		diff = (sample > stored) ? sample - stored : stored - sample;
		outside_band = DIFF_CMP_W'(diff) > DIFF_CMP_W'(cfg.deadband_width);
		accepted = (cfg.deadband_enable && !outside_band) ? stored : sample;
		changed = accepted != stored;
	end

	assign desc_valid    = accept && settled && changed;
	assign desc.channel  = ch_sel;
	assign desc.value    = accepted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_count_q  <= '0;
			channel_index_q <= CHANNEL_RST;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_value_q[i] <= '0;
			end
		end else if (accept) begin
			if (settled) begin
				settle_count_q  <= '0;
				channel_index_q <= next_ch;
				if (changed) begin
					chan_value_q[ch_sel[CH_SEL_W-1:0]] <= accepted;
				end
			end else begin
				settle_count_q <= settle_count_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/adsdr_queue.sv
// Short descriptor queue between the front end and the frame serializer.
// Depends on adsdr_pkg and the shared assertion macros.
`include "adc_scan_deadband_reporter_core_defines.svh"

module adsdr_queue import adsdr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  frame_desc_t   wr_data,
	input  logic          rd_en,
	output frame_desc_t   rd_data,
	output queue_status_t status
);

	frame_desc_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign rd_data      = mem_q[rd_ptr_q];
	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`ADSDR_ASSERT_NEVER(a_no_write_when_full, wr_en && status.full, "Descriptor written to full queue.")
	`ADSDR_ASSERT_NEVER(a_no_read_when_empty, rd_en && status.empty, "Descriptor read from empty queue.")
	`ADSDR_ASSERT(a_count_in_range, count_q <= QCNT_W'(QUEUE_DEPTH), "Queue count out of range.")
	`ADSDR_ASSERT(a_count_tracks_write, wr_en && !rd_en |=> count_q == QCNT_W'($past(count_q) + 1'b1), "Queue count missed a write.")

endmodule

>>> sv/adsdr_back.sv
// Back end: serializes each frame descriptor into five words on the result port.
// Depends on adsdr_pkg; reads the head of adsdr_queue.
module adsdr_back import adsdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  queue_status_t     qstat,
	input  frame_desc_t       head,
	output logic              rd_en,
	input  logic              pop,
	output logic              empty,
	output logic [BYTE_W-1:0] frame_byte,
	output logic              frame_last
);

	typedef enum logic [4:0] {
		POS_START   = 5'b00001,
		POS_CHANNEL = 5'b00010,
		POS_HIGH    = 5'b00100,
		POS_LOW     = 5'b01000,
		POS_STOP    = 5'b10000
	} byte_pos_t;

	byte_pos_t         pos_q;
	byte_pos_t         next_pos;
	logic              out_valid_q;
	logic [BYTE_W-1:0] frame_byte_q;
	logic              frame_last_q;
	logic [BYTE_W-1:0] next_byte;
	logic [EXT_W-1:0]  value_ext;
	logic              load;

	assign value_ext = EXT_W'(head.value);
	assign load      = !out_valid_q || pop;
	assign rd_en     = load && !qstat.empty && (pos_q == POS_STOP);

	always_comb begin
		case (pos_q)
			POS_START: begin
				next_byte = FRAME_START;
				next_pos  = POS_CHANNEL;
			end
			POS_CHANNEL: begin
				next_byte = BYTE_W'(head.channel);
				next_pos  = POS_HIGH;
			end
			POS_HIGH: begin
				next_byte = value_ext[EXT_W-1:BYTE_W];
				next_pos  = POS_LOW;
			end
			POS_LOW: begin
				next_byte = value_ext[BYTE_W-1:0];
				next_pos  = POS_STOP;
			end
			POS_STOP: begin
				next_byte = FRAME_STOP;
				next_pos  = POS_START;
			end
			default: begin
				next_byte = FRAME_START;
				next_pos  = POS_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_START;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !qstat.empty;
			if (!qstat.empty) begin
				pos_q <= next_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !qstat.empty) begin
			frame_byte_q <= next_byte;
			frame_last_q <= pos_q == POS_STOP;
		end
	end

	assign empty      = !out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_last = frame_last_q;

endmodule

>>> sv/adc_scan_deadband_reporter_core.sv
// Top level of the adc scan deadband reporter; holds the configuration registers.
// Takes one poll tick per cycle unless full; frames pass the queue, then the output register.
// Frame words leave at one per cycle while popped, five per frame, from a four-frame queue.
// full rises while that queue is full, from a burst of changed samples or a slow reader.
// Reset restores the register defaults, clears the counter and channel stores, selects channel 1.
// Depends on adsdr_pkg, adsdr_front, adsdr_queue and adsdr_back.
module adc_scan_deadband_reporter_core import adsdr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [IN_W-1:0]       adc_sample,
	output logic                  empty,
	input  logic                  pop,
	output logic [BYTE_W-1:0]     frame_byte,
	output logic                  frame_last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t          cfg_q;
	logic          accept;
	logic          desc_valid;
	frame_desc_t   desc;
	frame_desc_t   head;
	logic          rd_en;
	queue_status_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks     <= SETTLE_TICKS_RST;
			cfg_q.deadband_enable  <= 1'b0;
			cfg_q.deadband_width   <= DB_WIDTH_RST;
			cfg_q.expander_present <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SETTLE_TICKS: begin
					cfg_q.settle_ticks <= cfg_data[SETTLE_W-1:0];
				end
				REG_DEADBAND_ENABLE: begin
					cfg_q.deadband_enable <= cfg_data[0];
				end
				REG_DEADBAND_WIDTH: begin
					cfg_q.deadband_width <= cfg_data[DB_W-1:0];
				end
				REG_EXPANDER_PRESENT: begin
					cfg_q.expander_present <= cfg_data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	adsdr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.adc_sample (adc_sample),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	adsdr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_valid),
		.wr_data (desc),
		.rd_en   (rd_en),
		.rd_data (head),
		.status  (qstat)
	);

	adsdr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.rd_en      (rd_en),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule

>>> tb/sv/adsdr_frame_checker.sv
// Checker for the adc scan deadband reporter: tracks register writes and poll ticks,
// predicts the report frames and compares every popped word against them.
// Depends on adsdr_pkg; instantiated next to the block by the testbench top.
module adsdr_frame_checker import adsdr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [IN_W-1:0]       adc_sample,
	input  logic                  empty,
	input  logic                  pop,
	input  logic [BYTE_W-1:0]     frame_byte,
	input  logic                  frame_last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    ticks_seen,
	output int                    words_seen
);

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic              last;
	} frame_word_t;

	frame_word_t            expected_words[$];
	cfg_t                   regs;
	logic [CNT_W-1:0]       settle_cnt;
	logic [CH_W-1:0]        scan_ch;
	logic [SAMPLE_BITS-1:0] ch_store [NUM_CHANNELS];

	task automatic report(string what);
		$display("%0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic scan_tick(logic [IN_W-1:0] smp);
		logic [CH_W-1:0]        top_ch;
		int                     ch;
		int                     diff;
		logic [SAMPLE_BITS-1:0] value;
		logic [SAMPLE_BITS-1:0] stored;
		if (settle_cnt <= CNT_W'(regs.settle_ticks)) begin
			settle_cnt++;
			return;
		end
		settle_cnt = '0;
		top_ch = regs.expander_present ? CH_W'(LAST_CH_EXP) : CH_W'(LAST_CH_BASE);
		if (top_ch > NUM_CHANNELS - 1)
			top_ch = CH_W'(NUM_CHANNELS - 1);
		scan_ch = (scan_ch < top_ch) ? scan_ch + 1'b1 : '0;
		ch = (scan_ch >= NUM_CHANNELS) ? 0 : int'(scan_ch);
		value = smp[SAMPLE_BITS-1:0];
		stored = ch_store[ch];
		if (regs.deadband_enable) begin
			diff = (value > stored) ? int'(value) - int'(stored) : int'(stored) - int'(value);
			if (diff <= int'(regs.deadband_width))
				value = stored;
		end
		if (value == stored)
			return;
		ch_store[ch] = value;
		expected_words.push_back('{FRAME_START, 1'b0});
		expected_words.push_back('{BYTE_W'(ch), 1'b0});
		expected_words.push_back('{BYTE_W'(value >> 7), 1'b0});
		expected_words.push_back('{BYTE_W'(value), 1'b0});
		expected_words.push_back('{FRAME_STOP, 1'b1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			regs.settle_ticks = SETTLE_TICKS_RST;
			regs.deadband_enable = 1'b0;
			regs.deadband_width = DB_WIDTH_RST;
			regs.expander_present = 1'b0;
			settle_cnt = '0;
			scan_ch = CHANNEL_RST;
			foreach (ch_store[i])
				ch_store[i] = '0;
			expected_words.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					report($sformatf("word %0d: 0x%0h/%0b arrived with no frame pending",
						words_seen, frame_byte, frame_last));
				end else begin
					want = expected_words.pop_front();
					if (frame_byte !== want.code)
						report($sformatf("word %0d: frame_byte 0x%0h, expected 0x%0h",
							words_seen, frame_byte, want.code));
					if (frame_last !== want.last)
						report($sformatf("word %0d: frame_last %0b, expected %0b",
							words_seen, frame_last, want.last));
				end
			end
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SETTLE_TICKS: regs.settle_ticks = cfg_data[SETTLE_W-1:0];
					REG_DEADBAND_ENABLE: regs.deadband_enable = cfg_data[0];
					REG_DEADBAND_WIDTH: regs.deadband_width = cfg_data[DB_W-1:0];
					REG_EXPANDER_PRESENT: regs.expander_present = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				ticks_seen++;
				scan_tick(adc_sample);
			end
			pending <= expected_words.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the adc scan deadband reporter testbench: clock, reset, poll ticks,
// register writes and output pops; the verdict comes from adsdr_frame_checker.
// Depends on adsdr_pkg, adsdr_frame_checker and adc_scan_deadband_reporter_core.
module testbench;
	import adsdr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_PAUSE   = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [IN_W-1:0]       adc_sample;
	logic                  empty;
	logic                  pop;
	logic [BYTE_W-1:0]     frame_byte;
	logic                  frame_last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int              fail_count;
	int              pending;
	int              ticks_seen;
	int              words_seen;
	int              send_idle;
	int              recv_idle;
	int              hold_request;
	int              hold_left;
	int              quiet_cycles;
	int              full_stalls;
	int              settings_used;
	logic [IN_W-1:0] last_sample;

	adc_scan_deadband_reporter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.adc_sample (adc_sample),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	adsdr_frame_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.adc_sample (adc_sample),
		.empty      (empty),
		.pop        (pop),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.ticks_seen (ticks_seen),
		.words_seen (words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [IN_W-1:0] next_sample();
		logic [IN_W-1:0] v;
		int              pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			v = IN_W'($urandom);
		end else if (pick < 7) begin
			case ($urandom_range(0, 7))
				0: v = 10'd0;
				1: v = 10'd1;
				2: v = 10'd2;
				3: v = 10'd3;
				4: v = 10'd511;
				5: v = 10'd512;
				6: v = 10'd1022;
				default: v = 10'd1023;
			endcase
		end else begin
			v = last_sample + IN_W'($urandom_range(0, 6)) - IN_W'(3);
		end
		return v;
	endfunction

	task automatic send_item(logic [IN_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		adc_sample <= v;
		last_sample = v;
		do @(posedge clk); while (full);
	endtask

	task automatic send_pair(logic [IN_W-1:0] v);
		send_item(v);
		send_item(v);
	endtask

	task automatic wait_quiet();
		push <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_PAUSE) @(posedge clk);
	endtask

	task automatic set_config(logic [SETTLE_W-1:0] ticks, logic db_on,
		logic [DB_W-1:0] db_width, logic exp_on);
		cfg_we <= 1'b1;
		cfg_index <= REG_SETTLE_TICKS;
		cfg_data <= CFG_DATA_W'(ticks);
		@(posedge clk);
		cfg_index <= REG_DEADBAND_ENABLE;
		cfg_data <= CFG_DATA_W'(db_on);
		@(posedge clk);
		cfg_index <= REG_DEADBAND_WIDTH;
		cfg_data <= CFG_DATA_W'(db_width);
		@(posedge clk);
		cfg_index <= REG_EXPANDER_PRESENT;
		cfg_data <= CFG_DATA_W'(exp_on);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(logic [SETTLE_W-1:0] ticks, logic db_on,
		logic [DB_W-1:0] db_width, logic exp_on, int count, int hold);
		wait_quiet();
		set_config(ticks, db_on, db_width, exp_on);
		if (hold > 0)
			hold_request = hold;
		for (int i = 0; i < count; i++)
			send_item(next_sample());
	endtask

	// Receiver side: random pops, plus a long hold-off on request to back up the queue.
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (push && full)
			full_stalls <= full_stalls + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("adc_scan_deadband_reporter_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		adc_sample = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SETTLE_TICKS;
		cfg_data = '0;
		last_sample = '0;
		send_idle = 28;
		recv_idle = 51;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no settle wait every second tick takes a sample; walk the expander
		// channels, then drop the expander while the scan sits beyond channel 3.
		set_config(16'd0, 1'b0, 10'd1, 1'b1);
		send_pair(10'd1023);
		send_pair(10'd0);
		send_pair(10'd1);
		wait_quiet();
		set_config(16'd0, 1'b0, 10'd1, 1'b0);
		send_pair(10'd1023);
		// Deadband edges: a change equal to the width is dropped, one above it passes.
		wait_quiet();
		set_config(16'd0, 1'b1, 10'd1, 1'b0);
		send_pair(10'd1);
		send_pair(10'd1021);
		send_pair(10'd3);
		wait_quiet();
		set_config(16'd0, 1'b1, 10'd1023, 1'b0);
		send_pair(10'd0);
		send_pair(10'd1023);
		wait_quiet();
		set_config(16'd0, 1'b1, 10'd0, 1'b0);
		send_pair(10'd1022);
		send_pair(10'd3);

		run_phase(16'd0, 1'b0, 10'd1, 1'b0, 80, 0);
		run_phase(16'd1, 1'b1, 10'd0, 1'b1, 80, 0);
		send_idle = 51;
		recv_idle = 28;
		run_phase(16'd3, 1'b1, 10'd1023, 1'b0, 30, 0);
		run_phase(16'd0, 1'b1, 10'd2, 1'b1, 80, 0);
		send_idle = 0;
		recv_idle = 0;
		run_phase(16'd65535, 1'b0, 10'd1, 1'b1, 10, 0);
		run_phase(16'd0, 1'b0, 10'd1, 1'b1, 100, 300);
		run_phase(16'd7, 1'b1, 10'd5, 1'b0, 60, 0);
		wait_quiet();

		$display("Run covered %0d poll ticks and %0d frame words over %0d register settings,",
			ticks_seen, words_seen, settings_used);
		$display("with %0d cycles of the input held back by a full output queue.", full_stalls);
		if (fail_count == 0)
			$display("adc_scan_deadband_reporter_core: match");
		else
			$display("adc_scan_deadband_reporter_core: mismatch");
		$finish;
	end

endmodule
